FILE: rtl/core/md2vph_pkg.sv
package md2vph_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned BufBytes   = 48;
  localparam int unsigned Passes     = 18;

  localparam int unsigned FillW = $clog2(BlockBytes);
  localparam int unsigned StepW = $clog2(BufBytes);
  localparam int unsigned PassW = $clog2(Passes);

  localparam logic [7:0] SBOX [256] = '{
    8'hbd, 8'h56, 8'hea, 8'hf2, 8'ha2, 8'hf1, 8'hac, 8'h2a,
    8'hb0, 8'h93, 8'hd1, 8'h9c, 8'h1b, 8'h33, 8'hfd, 8'hd0,
    8'h30, 8'h04, 8'hb6, 8'hdc, 8'h7d, 8'hdf, 8'h32, 8'h4b,
    8'hf7, 8'hcb, 8'h45, 8'h9b, 8'h31, 8'hbb, 8'h21, 8'h5a,
    8'h41, 8'h9f, 8'he1, 8'hd9, 8'h4a, 8'h4d, 8'h9e, 8'hda,
    8'ha0, 8'h68, 8'h2c, 8'hc3, 8'h27, 8'h5f, 8'h80, 8'h36,
    8'h3e, 8'hee, 8'hfb, 8'h95, 8'h1a, 8'hfe, 8'hce, 8'ha8,
    8'h34, 8'ha9, 8'h13, 8'hf0, 8'ha6, 8'h3f, 8'hd8, 8'h0c,
    8'h78, 8'h24, 8'haf, 8'h23, 8'h52, 8'hc1, 8'h67, 8'h17,
    8'hf5, 8'h66, 8'h90, 8'he7, 8'he8, 8'h07, 8'hb8, 8'h60,
    8'h48, 8'he6, 8'h1e, 8'h53, 8'hf3, 8'h92, 8'ha4, 8'h72,
    8'h8c, 8'h08, 8'h15, 8'h6e, 8'h86, 8'h00, 8'h84, 8'hfa,
    8'hf4, 8'h7f, 8'h8a, 8'h42, 8'h19, 8'hf6, 8'hdb, 8'hcd,
    8'h14, 8'h8d, 8'h50, 8'h12, 8'hba, 8'h3c, 8'h06, 8'h4e,
    8'hec, 8'hb3, 8'h35, 8'h11, 8'ha1, 8'h88, 8'h8e, 8'h2b,
    8'h94, 8'h99, 8'hb7, 8'h71, 8'h74, 8'hd3, 8'he4, 8'hbf,
    8'h3a, 8'hde, 8'h96, 8'h0e, 8'hbc, 8'h0a, 8'hed, 8'h77,
    8'hfc, 8'h37, 8'h6b, 8'h03, 8'h79, 8'h89, 8'h62, 8'hc6,
    8'hd7, 8'hc0, 8'hd2, 8'h7c, 8'h6a, 8'h8b, 8'h22, 8'ha3,
    8'h5b, 8'h05, 8'h5d, 8'h02, 8'h75, 8'hd5, 8'h61, 8'he3,
    8'h18, 8'h8f, 8'h55, 8'h51, 8'had, 8'h1f, 8'h0b, 8'h5e,
    8'h85, 8'he5, 8'hc2, 8'h57, 8'h63, 8'hca, 8'h3d, 8'h6c,
    8'hb4, 8'hc5, 8'hcc, 8'h70, 8'hb2, 8'h91, 8'h59, 8'h0d,
    8'h47, 8'h20, 8'hc8, 8'h4f, 8'h58, 8'he0, 8'h01, 8'he2,
    8'h16, 8'h38, 8'hc4, 8'h6f, 8'h3b, 8'h0f, 8'h65, 8'h46,
    8'hbe, 8'h7e, 8'h2d, 8'h7b, 8'h82, 8'hf9, 8'h40, 8'hb5,
    8'h1d, 8'h73, 8'hf8, 8'heb, 8'h26, 8'hc7, 8'h87, 8'h97,
    8'h25, 8'h54, 8'hb1, 8'h28, 8'haa, 8'h98, 8'h9d, 8'ha5,
    8'h64, 8'h6d, 8'h7a, 8'hd4, 8'h10, 8'h81, 8'h44, 8'hef,
    8'h49, 8'hd6, 8'hae, 8'h2e, 8'hdd, 8'h76, 8'h5c, 8'h2f,
    8'ha7, 8'h1c, 8'hc9, 8'h09, 8'h69, 8'h9a, 8'h83, 8'hcf,
    8'h29, 8'h39, 8'hb9, 8'he9, 8'h4c, 8'hff, 8'h43, 8'hab
  };

  typedef struct packed {
    logic wr_byte;
    logic pad;
    logic cks_step;
    logic load_blk;
    logic load_cks;
    logic comp_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fill_full;
    logic cks_last;
    logic comp_last;
  } dp_status_t;

endpackage

FILE: rtl/core/md2vph_datapath.sv
module md2vph_datapath
  import md2vph_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  input  logic [7:0]       msg_byte_i,
  output dp_status_t       status_o,
  output logic [63:0]      digest_high_o,
  output logic [63:0]      digest_low_o
);

  logic [7:0]       blk_q [BlockBytes];
  logic [7:0]       cks_q [BlockBytes];
  logic [7:0]       buf_q [BufBytes];
  logic [FillW-1:0] fill_q;
  logic [StepW-1:0] step_q;
  logic [PassW-1:0] pass_q;
  logic [7:0]       carry_q;
  logic [63:0]      dig_hi_q, dig_lo_q;

  logic [7:0]       comp_idx;
  logic [7:0]       comp_new;
  logic [7:0]       cks_new;
  logic [7:0]       pad_val;
  logic             step_end;
  logic             pass_end;

  // buffer rotates one byte per step, so the active byte always sits at the head
  assign comp_idx = carry_q + (8'(BufBytes) - 8'(step_q));
  assign comp_new = buf_q[0] ^ SBOX[comp_idx];
  // after each rotation the last updated checksum byte is at the tail
  assign cks_new  = cks_q[0] ^ SBOX[blk_q[0] ^ cks_q[BlockBytes-1]];
  assign pad_val  = 8'(BlockBytes) - 8'(fill_q);

  assign step_end = (step_q == StepW'(BufBytes - 1));
  assign pass_end = (pass_q == PassW'(Passes - 1));

  assign status_o.fill_full = (fill_q == FillW'(BlockBytes - 1));
  assign status_o.cks_last  = (step_q == StepW'(BlockBytes - 1));
  assign status_o.comp_last = step_end && pass_end;

  // pending block, no reset: entries are written before they are read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      blk_q[fill_q] <= msg_byte_i;
    end else if (cmd_i.pad) begin
      for (int k = 0; k < BlockBytes; k++) begin
        if (FillW'(k) >= fill_q) blk_q[k] <= pad_val;
      end
    end else if (cmd_i.cks_step) begin
      for (int k = 0; k < BlockBytes - 1; k++) blk_q[k] <= blk_q[k+1];
      blk_q[BlockBytes-1] <= blk_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      step_q <= '0;
      pass_q <= '0;
      for (int k = 0; k < BlockBytes; k++) cks_q[k] <= '0;
      for (int k = 0; k < BufBytes; k++) buf_q[k] <= '0;
    end else if (cmd_i.finish) begin
      fill_q <= '0;
      step_q <= '0;
      pass_q <= '0;
      for (int k = 0; k < BlockBytes; k++) cks_q[k] <= '0;
      for (int k = 0; k < BufBytes; k++) buf_q[k] <= '0;
    end else begin
      if (cmd_i.wr_byte) fill_q <= fill_q + FillW'(1);
      if (cmd_i.cks_step) begin
        for (int k = 0; k < BlockBytes - 1; k++) cks_q[k] <= cks_q[k+1];
        cks_q[BlockBytes-1] <= cks_new;
        step_q <= status_o.cks_last ? '0 : step_q + StepW'(1);
      end
      if (cmd_i.load_blk || cmd_i.load_cks) begin
        step_q <= '0;
        pass_q <= '0;
        for (int k = 0; k < BlockBytes; k++) begin
          buf_q[BlockBytes + k]   <= cmd_i.load_cks ? cks_q[k] : blk_q[k];
          buf_q[2*BlockBytes + k] <= (cmd_i.load_cks ? cks_q[k] : blk_q[k]) ^ buf_q[k];
        end
      end
      if (cmd_i.comp_step) begin
        for (int k = 0; k < BufBytes - 1; k++) buf_q[k] <= buf_q[k+1];
        buf_q[BufBytes-1] <= comp_new;
        if (step_end) begin
          step_q <= '0;
          pass_q <= pass_end ? '0 : pass_q + PassW'(1);
        end else begin
          step_q <= step_q + StepW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_blk || cmd_i.load_cks) begin
      carry_q <= '0;
    end else if (cmd_i.comp_step) begin
      carry_q <= comp_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      for (int k = 0; k < 8; k++) begin
        dig_hi_q[63 - 8*k -: 8] <= buf_q[k];
        dig_lo_q[63 - 8*k -: 8] <= buf_q[8 + k];
      end
    end
  end

  assign digest_high_o = dig_hi_q;
  assign digest_low_o  = dig_lo_q;

endmodule

FILE: rtl/core/md2vph_ctrl.sv
module md2vph_ctrl
  import md2vph_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       has_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StCks  = 3'd2;
  localparam logic [2:0] StLoad = 3'd3;
  localparam logic [2:0] StComp = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  localparam logic [1:0] PhData  = 2'd0;
  localparam logic [1:0] PhPad   = 2'd1;
  localparam logic [1:0] PhFinal = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;
  logic       in_xfer;
  logic       out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          cmd_o.wr_byte = has_byte_i;
          last_d        = last_i;
          if (has_byte_i && status_i.fill_full) begin
            phase_d = PhData;
            state_d = StCks;
          end else if (last_i) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        cmd_o.pad = 1'b1;
        phase_d   = PhPad;
        state_d   = StCks;
      end
      StCks: begin
        cmd_o.cks_step = 1'b1;
        if (status_i.cks_last) state_d = StLoad;
      end
      StLoad: begin
        cmd_o.load_cks = (phase_q == PhFinal);
        cmd_o.load_blk = (phase_q != PhFinal);
        state_d        = StComp;
      end
      StComp: begin
        cmd_o.comp_step = 1'b1;
        if (status_i.comp_last) begin
          case (phase_q)
            PhData:  state_d = last_q ? StPad : StIdle;
            PhPad: begin
              phase_d = PhFinal;
              state_d = StLoad;
            end
            default: state_d = StFin;
          endcase
        end
      end
      StFin: begin
        // digest waits here until the output register is free
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          last_d       = 1'b0;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= PhData;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/md2_variant_password_hash.sv
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o    msg_byte_i, has_byte_i, last_i
// out       output     out_valid_o / out_stall_i  digest_high_o, digest_low_o
//
// a byte that does not complete a block leaves the input free; a byte that completes one
// stalls the input for 16 checksum steps, a buffer load and 864 s-box steps in series
// a last item adds padding and two more compressions, then the digest
// reset clears hash state, checksum and fill count; the digest register holds no reset value
// a finished digest waits in its output register; the next item is taken meanwhile
module md2_variant_password_hash
  import md2vph_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_high_o,
  output logic [63:0] digest_low_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  md2vph_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .has_byte_i  (has_byte_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  md2vph_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .msg_byte_i    (msg_byte_i),
    .status_o      (status),
    .digest_high_o (digest_high_o),
    .digest_low_o  (digest_low_o)
  );

endmodule

FILE: dv/md2_variant_password_hash_tb.sv
`timescale 1ns / 100ps

module md2_variant_password_hash_tb;
  import md2vph_pkg::*;

  localparam int unsigned RandItems     = 1950;
  localparam int unsigned HoldCycles    = 20000;
  localparam int unsigned WatchdogLimit = 100000;
  localparam int unsigned TailCycles    = 2000;
  localparam int unsigned DirRows       = 25;

  typedef logic [BlockBytes-1:0][7:0] block_t;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } digest_t;

  typedef enum int unsigned {
    StallNone,
    StallRandom,
    StallRuns
  } stall_mode_e;

  // directed rows: {msg_byte, has_byte, last}
  localparam logic [9:0] DirStim [DirRows] = '{
    {8'h00, 1'b0, 1'b1},  // empty message
    {8'h5a, 1'b0, 1'b0},  // no byte, not last: ignored
    {8'h00, 1'b1, 1'b1},  // single zero byte
    {8'hff, 1'b1, 1'b1},
    {8'h00, 1'b1, 1'b0},
    {8'hff, 1'b1, 1'b0},
    {8'haa, 1'b0, 1'b0},
    {8'h55, 1'b1, 1'b0},
    {8'h01, 1'b0, 1'b1},  // empty final item after three bytes
    {8'h80, 1'b1, 1'b0},
    {8'h40, 1'b1, 1'b0},
    {8'h20, 1'b1, 1'b0},
    {8'h10, 1'b1, 1'b0},
    {8'h08, 1'b1, 1'b0},
    {8'h04, 1'b1, 1'b0},
    {8'h02, 1'b1, 1'b0},
    {8'h01, 1'b1, 1'b0},
    {8'hfe, 1'b1, 1'b0},
    {8'hfd, 1'b1, 1'b0},
    {8'hfb, 1'b1, 1'b0},
    {8'hf7, 1'b1, 1'b0},
    {8'hef, 1'b1, 1'b0},
    {8'hdf, 1'b1, 1'b0},
    {8'hbf, 1'b1, 1'b0},
    {8'h7f, 1'b1, 1'b1}   // length 16: full pad block follows
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  msg_byte;
  logic        has_byte;
  logic        last;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] digest_high;
  logic [63:0] digest_low;

  block_t      pend_bytes;
  int unsigned fill_cnt;
  block_t      hash_st;
  block_t      sum_st;
  digest_t     expected_digests [$];

  int unsigned errors;
  int unsigned msg_items_sent;
  int unsigned burst_left;
  int unsigned quiet_cycles;
  bit          hold_req;
  bit          hold_done;

  md2_variant_password_hash i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .msg_byte_i    (msg_byte),
    .has_byte_i    (has_byte),
    .last_i        (last),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .digest_high_o (digest_high),
    .digest_low_o  (digest_low)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_hash();
    pend_bytes = '0;
    fill_cnt   = 0;
    hash_st    = '0;
    sum_st     = '0;
  endfunction

  // one compression: 18 chained s-box passes over state, block and their xor; also updates the checksum
  function automatic void mix_block(input block_t blk);
    logic [7:0] mix [BufBytes];
    logic [7:0] carry;
    logic [7:0] idx;
    logic [7:0] link;
    carry = 8'h00;
    for (int p = 0; p < BlockBytes; p++) begin
      mix[p]                = hash_st[p];
      mix[BlockBytes + p]   = blk[p];
      mix[2*BlockBytes + p] = blk[p] ^ hash_st[p];
    end
    for (int r = 0; r < Passes; r++) begin
      for (int p = 0; p < BufBytes; p++) begin
        idx    = carry + 8'(BufBytes - p);
        mix[p] = mix[p] ^ SBOX[idx];
        carry  = mix[p];
      end
    end
    for (int p = 0; p < BlockBytes; p++) begin
      hash_st[p] = mix[p];
    end
    link = sum_st[BlockBytes-1];
    for (int p = 0; p < BlockBytes; p++) begin
      sum_st[p] = sum_st[p] ^ SBOX[blk[p] ^ link];
      link      = sum_st[p];
    end
  endfunction

  function automatic void absorb_item(input logic [7:0] b, input logic hb, input logic lt);
    digest_t    d;
    logic [7:0] padv;
    if (hb) begin
      pend_bytes[fill_cnt] = b;
      fill_cnt++;
      if (fill_cnt == BlockBytes) begin
        mix_block(pend_bytes);
        fill_cnt = 0;
      end
    end
    if (lt) begin
      padv = 8'(BlockBytes - fill_cnt);
      for (int k = fill_cnt; k < BlockBytes; k++) begin
        pend_bytes[k] = padv;
      end
      mix_block(pend_bytes);
      mix_block(sum_st);
      d = '0;
      for (int k = 0; k < 8; k++) begin
        d.high = {d.high[55:0], hash_st[k]};
        d.low  = {d.low[55:0], hash_st[8 + k]};
      end
      expected_digests.push_back(d);
      clear_hash();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
    errors++;
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic [7:0] b, input logic hb, input logic lt);
    msg_byte <= b;
    has_byte <= hb;
    last     <= lt;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    absorb_item(b, hb, lt);
    if (hb || lt) msg_items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int unsigned pick;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 80) repeat ($urandom_range(1, 4)) @(negedge clk);
      else if (pick < 95) repeat ($urandom_range(5, 30)) @(negedge clk);
      else repeat ($urandom_range(100, 300)) @(negedge clk);
      pick = $urandom_range(0, 9);
      burst_left = (pick == 0) ? $urandom_range(50, 200) : $urandom_range(0, 15);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_digests.size() != 0);
  endtask

  initial begin
    logic [9:0]  row;
    int unsigned len;
    int unsigned body;
    int unsigned pick;
    bit          empty_end;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    msg_byte       = 8'h00;
    has_byte       = 1'b0;
    last           = 1'b0;
    errors         = 0;
    msg_items_sent = 0;
    burst_left     = 0;
    hold_req       = 1'b0;
    clear_hash();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < DirRows; i++) begin
      row = DirStim[i];
      send_item(row[9:2], row[1], row[0]);
      if (i == DirRows - 1) drain_results();
      else idle_gap();
    end

    hold_req       = 1'b1;
    msg_items_sent = 0;
    while (msg_items_sent < RandItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) len = $urandom_range(0, 20);
      else if (pick < 90) len = $urandom_range(21, 48);
      else len = $urandom_range(49, 96);
      empty_end = (len == 0) || ($urandom_range(0, 1) == 1);
      body = empty_end ? len : len - 1;
      for (int i = 0; i < body; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          idle_gap();
        end
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        idle_gap();
      end
      send_item(8'($urandom_range(0, 255)), !empty_end, 1'b1);
      if (msg_items_sent >= RandItems || $urandom_range(0, 19) == 0) drain_results();
      else idle_gap();
    end

    repeat (TailCycles) @(negedge clk);
    if (errors == 0) begin
      $display("md2_variant_password_hash test passed");
    end else begin
      $display("md2_variant_password_hash test failed");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off once random traffic starts
  initial begin
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned run_left;
    bit          run_stall;
    mode      = StallNone;
    mode_left = 0;
    run_left  = 0;
    run_stall = 1'b0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(64, 512);
      end
      mode_left--;
      case (mode)
        StallNone: begin
          out_stall <= 1'b0;
        end
        StallRandom: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          if (run_left == 0) begin
            run_stall = !run_stall;
            run_left  = $urandom_range(1, 40);
          end
          run_left--;
          out_stall <= run_stall;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    digest_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_digests.size() == 0) begin
        report_mismatch("digest with no message pending", 64'h0, digest_high);
      end else begin
        want = expected_digests.pop_front();
        if (digest_high !== want.high) report_mismatch("digest_high", want.high, digest_high);
        if (digest_low !== want.low) report_mismatch("digest_low", want.low, digest_low);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("md2_variant_password_hash test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
rtl/core/md2vph_pkg.sv
rtl/core/md2vph_datapath.sv
rtl/core/md2vph_ctrl.sv
rtl/core/md2_variant_password_hash.sv
dv/md2_variant_password_hash_tb.sv
